// ===== hw/rtl/cdd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared types, constants and calendar tables for the calendar date
// difference block.
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 23;
  localparam int unsigned Q100_W  = 8;   // floor(year / 100) for a 14-bit year
  localparam int unsigned LEAPS_W = 12;  // leap years in 1..year
  localparam int unsigned DOY_W   = 9;   // day of year, 1..366

  // Divide by 100 as multiply by 5243 and shift by 19; exact below 43690
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned CENTURY     = 100;
  localparam int unsigned DAYS_YEAR   = 365;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  later_year;
    logic [MONTH_W-1:0] later_month;
    logic [DAY_W-1:0]   later_day;
    logic [YEAR_W-1:0]  earlier_year;
    logic [MONTH_W-1:0] earlier_month;
    logic [DAY_W-1:0]   earlier_day;
  } req_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] day_count;
    logic                      date_invalid;
  } rsp_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // Per-date summary handed from the date unit to the difference stages
  typedef struct packed {
    logic               ok;
    logic [LEAPS_W-1:0] leaps;
    logic [DOY_W-1:0]   doy;
    logic [YEAR_W-1:0]  year;
  } date_info_t;

  // Month length, February as in a leap year; zero for a bad month
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of the month in a common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] sum;
    case (m)
      4'd1:    sum = 9'd0;
      4'd2:    sum = 9'd31;
      4'd3:    sum = 9'd59;
      4'd4:    sum = 9'd90;
      4'd5:    sum = 9'd120;
      4'd6:    sum = 9'd151;
      4'd7:    sum = 9'd181;
      4'd8:    sum = 9'd212;
      4'd9:    sum = 9'd243;
      4'd10:   sum = 9'd273;
      4'd11:   sum = 9'd304;
      4'd12:   sum = 9'd334;
      default: sum = 9'd0;
    endcase
    return sum;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cdd_date_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdd_date_unit
// Two-stage check of one date: century quotient first, then leap flag,
// leap count up to the year, day of year and validity.
// ----------------------------------------------------------------------------
module cdd_date_unit (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire cdd_pkg::date_t     date,
  input  wire logic               year_ok,
  output cdd_pkg::date_info_t     info
);

  logic [cdd_pkg::PROD_W-1:0]  recip_prod;
  logic [cdd_pkg::Q100_W-1:0]  q100_next;

  logic [cdd_pkg::YEAR_W-1:0]  year_a;
  logic [cdd_pkg::MONTH_W-1:0] month_a;
  logic [cdd_pkg::DAY_W-1:0]   day_a;
  logic [cdd_pkg::Q100_W-1:0]  q100_a;
  logic                        month_ok_a;
  logic                        year_ok_a;

  logic [cdd_pkg::YEAR_W-1:0]  hundreds;
  logic                        leap;
  logic [cdd_pkg::DAY_W-1:0]   limit;
  logic                        day_ok;
  cdd_pkg::date_info_t         info_next;

  // Divide the year by 100 through the reciprocal
  assign recip_prod = cdd_pkg::PROD_W'(date.year) *
                      cdd_pkg::PROD_W'(cdd_pkg::RECIP_100);
  assign q100_next  = recip_prod[cdd_pkg::RECIP_SHIFT +: cdd_pkg::Q100_W];

  // Stage A: hold quotient and range flags
  always_ff @(posedge clk) begin
    if (en) begin
      year_a     <= date.year;
      month_a    <= date.month;
      day_a      <= date.day;
      q100_a     <= q100_next;
      month_ok_a <= (date.month >= cdd_pkg::MONTH_JAN) &&
                    (date.month <= cdd_pkg::MONTH_DEC);
      year_ok_a  <= year_ok;
    end
  end

  // Leap by the 4/100/400 rule; a century year needs its quotient divisible by 4
  assign hundreds = cdd_pkg::YEAR_W'(q100_a) * cdd_pkg::YEAR_W'(cdd_pkg::CENTURY);
  assign leap     = (year_a[1:0] == 2'b00) &&
                    ((hundreds != year_a) || (q100_a[1:0] == 2'b00));
  assign limit    = cdd_pkg::month_days(month_a, leap);
  assign day_ok   = (day_a != '0) && (day_a <= limit);

  always_comb begin
    info_next.ok    = month_ok_a && year_ok_a && day_ok;
    info_next.leaps = cdd_pkg::LEAPS_W'(year_a[cdd_pkg::YEAR_W-1:2])
                    - cdd_pkg::LEAPS_W'(q100_a)
                    + cdd_pkg::LEAPS_W'(q100_a[cdd_pkg::Q100_W-1:2]);
    info_next.doy   = cdd_pkg::days_before(month_a)
                    + cdd_pkg::DOY_W'(day_a)
                    + cdd_pkg::DOY_W'(leap && (month_a > cdd_pkg::MONTH_FEB));
    info_next.year  = year_a;
  end

  // Stage B: hold the date summary
  always_ff @(posedge clk) begin
    if (en) begin
      info <= info_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/calendar_date_difference.sv =====
// Each accepted request word gives one response word, in request order.
// Throughput: one word per cycle while no response is stalled; four register stages,
// each with at most one small multiplier per date (divide by 100, leap check, years times 365).
// A stalled response freezes every stage and stalls the request side.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_difference
// Days between two Gregorian dates; either date invalid gives -1 and the
// invalid flag.
// ----------------------------------------------------------------------------
module calendar_date_difference #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire cdd_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output cdd_pkg::rsp_t      rsp
);

  localparam int unsigned LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] YEAR_LIMIT = LIMIT_W'(MAX_YEAR);

  logic                 en;
  logic                 valid_a;
  logic                 valid_b;
  logic                 valid_c;

  cdd_pkg::date_t       later_date;
  cdd_pkg::date_t       earlier_date;
  cdd_pkg::date_info_t  later_info;
  cdd_pkg::date_info_t  earlier_info;

  logic [cdd_pkg::YEAR_W-1:0]  span;
  logic                        gt_c;
  logic                        bad_c;
  logic [cdd_pkg::COUNT_W-1:0] years_c;
  logic [cdd_pkg::LEAPS_W:0]   leap_diff_c;
  logic [cdd_pkg::DOY_W:0]     doy_diff_c;
  logic [cdd_pkg::COUNT_W-1:0] count_next;

  // Advance all stages together unless the response is held
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  assign later_date   = '{year: req.later_year, month: req.later_month,
                          day: req.later_day};
  assign earlier_date = '{year: req.earlier_year, month: req.earlier_month,
                          day: req.earlier_day};

  cdd_date_unit u_later (
    .clk     (clk),
    .en      (en),
    .date    (later_date),
    .year_ok (LIMIT_W'(req.later_year) <= YEAR_LIMIT),
    .info    (later_info)
  );

  cdd_date_unit u_earlier (
    .clk     (clk),
    .en      (en),
    .date    (earlier_date),
    .year_ok (LIMIT_W'(req.earlier_year) <= YEAR_LIMIT),
    .info    (earlier_info)
  );

  // Track stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= req_valid;
      valid_b   <= valid_a;
      valid_c   <= valid_b;
      rsp_valid <= valid_c;
    end
  end

  // Stage C: whole years as 365 days each and the leap delta when the later year is larger, plus the day-of-year delta
  assign span = later_info.year - earlier_info.year;

  always_ff @(posedge clk) begin
    if (en) begin
      gt_c        <= later_info.year > earlier_info.year;
      bad_c       <= !(later_info.ok && earlier_info.ok);
      years_c     <= (later_info.year > earlier_info.year) ?
                     cdd_pkg::COUNT_W'(span) * cdd_pkg::COUNT_W'(cdd_pkg::DAYS_YEAR) :
                     '0;
      leap_diff_c <= (later_info.year > earlier_info.year) ?
                     {1'b0, later_info.leaps} - {1'b0, earlier_info.leaps} : '0;
      doy_diff_c  <= {1'b0, later_info.doy} - {1'b0, earlier_info.doy};
    end
  end

  // Add the deltas sign-extended; drop to -1 on a bad date
  assign count_next = bad_c ? '1 :
                      years_c
                      + {{(cdd_pkg::COUNT_W-cdd_pkg::LEAPS_W-1){leap_diff_c[cdd_pkg::LEAPS_W]}},
                         leap_diff_c}
                      + {{(cdd_pkg::COUNT_W-cdd_pkg::DOY_W-1){doy_diff_c[cdd_pkg::DOY_W]}},
                         doy_diff_c};

  // Stage D: output register
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.day_count    <= count_next;
      rsp.date_invalid <= bad_c;
    end
  end

  // An accepted word occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> valid_a)
    else $error("accepted word did not enter the pipeline");

  // No year term when the later year is not larger
  a_years: assert property (@(posedge clk) disable iff (rst)
    (valid_c && !gt_c) |-> (years_c == '0 && leap_diff_c == '0))
    else $error("year span counted for a non-increasing year");

  // An invalid word always reports minus one
  a_invalid: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.date_invalid) |-> (rsp.day_count == '1))
    else $error("invalid date without count of minus one");

endmodule
`default_nettype wire

// ===== test/calendar_date_difference_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_difference_tb
// Drives date pairs through the request channel and checks every response
// word, field by field, against expected values from a directed table or a
// day-gap predictor in this file. A short table of directed pairs comes first,
// then random pairs in three phases with different idle and back-pressure rates.
// ----------------------------------------------------------------------------
module calendar_date_difference_tb;

  localparam int MAX_YEAR         = 9999;
  localparam int YEAR_TOP         = 2 ** cdd_pkg::YEAR_W - 1;
  localparam int CLK_HALF         = 4;
  localparam int RESET_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 217;
  localparam int DRAIN_CYCLES     = 16;
  localparam int STUCK_LIMIT      = 2000;
  localparam cdd_pkg::rsp_t BAD_DATE = {{cdd_pkg::COUNT_W{1'b1}}, 1'b1};

  typedef struct packed {
    cdd_pkg::req_t word;
    logic          typed;
    cdd_pkg::rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  cdd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  cdd_pkg::rsp_t rsp;

  // Expected response of the word on the request port, held with it
  cdd_pkg::rsp_t word_gap = '0;
  cdd_pkg::rsp_t expected_gaps[$];
  dir_row_t dir_rows[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int errors = 0;
  int stuck_cycles = 0;

  calendar_date_difference #(
    .MAX_YEAR(MAX_YEAR)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #(CLK_HALF) clk = ~clk;

  // Day-gap predictor
  function automatic bit gregorian_leap(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int leaps_through(int y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic int days_in_month(int m, int y);
    if (m == int'(cdd_pkg::MONTH_FEB)) begin
      return gregorian_leap(y) ? 29 : 28;
    end
    case (m)
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Day of year, or zero for a bad date
  function automatic int ordinal_day(int y, int m, int d);
    int sum;
    if (y > MAX_YEAR || m < int'(cdd_pkg::MONTH_JAN) || m > int'(cdd_pkg::MONTH_DEC)) begin
      return 0;
    end
    if (d < 1 || d > days_in_month(m, y)) begin
      return 0;
    end
    sum = d;
    for (int k = int'(cdd_pkg::MONTH_JAN); k < m; k++) begin
      sum += days_in_month(k, y);
    end
    return sum;
  endfunction

  function automatic cdd_pkg::rsp_t predict_day_gap(cdd_pkg::req_t w);
    cdd_pkg::rsp_t r;
    int ldoy;
    int edoy;
    int ly;
    int ey;
    int gap;
    ly = int'(w.later_year);
    ey = int'(w.earlier_year);
    ldoy = ordinal_day(ly, int'(w.later_month), int'(w.later_day));
    edoy = ordinal_day(ey, int'(w.earlier_month), int'(w.earlier_day));
    if (ldoy == 0 || edoy == 0) begin
      return BAD_DATE;
    end
    gap = 0;
    // Whole years only count when the later year is past the earlier one
    if (ly > ey) begin
      gap = (ly - ey) * 365 + leaps_through(ly) - leaps_through(ey);
    end
    gap = gap - edoy + ldoy;
    r.day_count = cdd_pkg::COUNT_W'(gap);
    r.date_invalid = 1'b0;
    return r;
  endfunction

  // Stimulus helpers
  function automatic cdd_pkg::req_t mk_dates(int ly, int lm, int ld, int ey, int em, int ed);
    cdd_pkg::req_t w;
    w.later_year    = cdd_pkg::YEAR_W'(ly);
    w.later_month   = cdd_pkg::MONTH_W'(lm);
    w.later_day     = cdd_pkg::DAY_W'(ld);
    w.earlier_year  = cdd_pkg::YEAR_W'(ey);
    w.earlier_month = cdd_pkg::MONTH_W'(em);
    w.earlier_day   = cdd_pkg::DAY_W'(ed);
    return w;
  endfunction

  function automatic cdd_pkg::rsp_t good_gap(int n);
    cdd_pkg::rsp_t r;
    r.day_count = cdd_pkg::COUNT_W'(n);
    r.date_invalid = 1'b0;
    return r;
  endfunction

  task automatic add_row(cdd_pkg::req_t w, logic typed, cdd_pkg::rsp_t want);
    dir_row_t row;
    row.word = w;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  function automatic cdd_pkg::date_t pick_valid_date();
    cdd_pkg::date_t dt;
    int y;
    int m;
    int len;
    // Bias years toward century boundaries and both ends of the range
    case ($urandom_range(3))
      0:       y = $urandom_range(99) * 100 + $urandom_range(4);
      1:       y = $urandom_range(1) ? $urandom_range(8) : MAX_YEAR - $urandom_range(8);
      default: y = $urandom_range(MAX_YEAR);
    endcase
    m = $urandom_range(int'(cdd_pkg::MONTH_DEC), int'(cdd_pkg::MONTH_JAN));
    len = days_in_month(m, y);
    dt.year = cdd_pkg::YEAR_W'(y);
    dt.month = cdd_pkg::MONTH_W'(m);
    dt.day = cdd_pkg::DAY_W'(($urandom_range(3) == 0) ? len : $urandom_range(len, 1));
    return dt;
  endfunction

  function automatic cdd_pkg::date_t spoil_date(cdd_pkg::date_t dt);
    int len;
    case ($urandom_range(3))
      0: dt.month = $urandom_range(1) ? cdd_pkg::MONTH_W'(0)
                    : cdd_pkg::MONTH_W'(int'(cdd_pkg::MONTH_DEC) + $urandom_range(3, 1));
      1: dt.day = '0;
      2: begin
        len = days_in_month(int'(dt.month), int'(dt.year));
        dt.day = (len < 31) ? cdd_pkg::DAY_W'($urandom_range(31, len + 1))
                            : cdd_pkg::DAY_W'(0);
      end
      default: dt.year = cdd_pkg::YEAR_W'($urandom_range(YEAR_TOP, MAX_YEAR + 1));
    endcase
    return dt;
  endfunction

  function automatic cdd_pkg::req_t random_dates();
    logic [63:0] raw;
    cdd_pkg::date_t lat;
    cdd_pkg::date_t ear;
    cdd_pkg::date_t tmp;
    int unsigned pick;
    int len;
    pick = $urandom_range(99);
    // Raw noise over every bit of every field
    if (pick < 6) begin
      raw = {$urandom, $urandom};
      return raw[$bits(cdd_pkg::req_t)-1:0];
    end
    lat = pick_valid_date();
    ear = pick_valid_date();
    // Same year now and then; clamp the day in case February shrank
    if ($urandom_range(4) == 0) begin
      ear.year = lat.year;
      len = days_in_month(int'(ear.month), int'(ear.year));
      if (int'(ear.day) > len) begin
        ear.day = cdd_pkg::DAY_W'(len);
      end
    end
    // Keep most pairs in order, leave the rest in the order drawn
    if (pick < 80 && lat.year < ear.year) begin
      tmp = lat;
      lat = ear;
      ear = tmp;
    end
    if (pick >= 88) begin
      case ($urandom_range(2))
        0:       lat = spoil_date(lat);
        1:       ear = spoil_date(ear);
        default: begin
          lat = spoil_date(lat);
          ear = spoil_date(ear);
        end
      endcase
    end
    return {lat, ear};
  endfunction

  // Request side: random idle, then hold the word until accepted
  task automatic send_word(cdd_pkg::req_t w, cdd_pkg::rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    word_gap <= want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_gaps.size() != 0) @(posedge clk);
  endtask

  // Response side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Queue accepted words, check response words, watch for a hang
  always @(posedge clk) begin
    cdd_pkg::rsp_t want;
    logic took_req;
    logic took_rsp;
    took_req = !rst && req_valid && !req_stall;
    took_rsp = !rst && rsp_valid && !rsp_stall;
    if (took_req) begin
      expected_gaps.push_back(word_gap);
    end
    if (took_rsp) begin
      if (expected_gaps.size() == 0) begin
        $display("%0t: unexpected response word, expected none, got day_count %0d date_invalid %0b",
                 $time, rsp.day_count, rsp.date_invalid);
        errors++;
      end else begin
        want = expected_gaps.pop_front();
        if (rsp.day_count !== want.day_count) begin
          $display("%0t: day_count expected %0d, got %0d",
                   $time, want.day_count, rsp.day_count);
          errors++;
        end
        if (rsp.date_invalid !== want.date_invalid) begin
          $display("%0t: date_invalid expected %0b, got %0b",
                   $time, want.date_invalid, rsp.date_invalid);
          errors++;
        end
      end
    end
    if (rst || took_req || took_rsp || (!req_valid && expected_gaps.size() == 0)) begin
      stuck_cycles = 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles++;
    end
  end

  initial begin
    dir_row_t row;

    // Bad months, bad days, years past the top, both dates bad
    add_row(mk_dates(2001, 0, 15, 2000, 1, 1), 1'b1, BAD_DATE);
    add_row(mk_dates(2001, 13, 15, 2000, 1, 1), 1'b1, BAD_DATE);
    add_row(mk_dates(2001, 3, 1, 2000, 15, 31), 1'b1, BAD_DATE);
    add_row(mk_dates(2001, 3, 1, 2000, 3, 0), 1'b1, BAD_DATE);
    add_row(mk_dates(2001, 4, 31, 2000, 1, 1), 1'b1, BAD_DATE);
    add_row(mk_dates(2001, 3, 1, 1900, 2, 29), 1'b1, BAD_DATE);
    add_row(mk_dates(2100, 2, 29, 2000, 1, 1), 1'b1, BAD_DATE);
    add_row(mk_dates(MAX_YEAR + 1, 1, 1, 2000, 1, 1), 1'b1, BAD_DATE);
    add_row(mk_dates(2000, 1, 1, YEAR_TOP, 1, 1), 1'b1, BAD_DATE);
    add_row(mk_dates(0, 0, 0, 0, 0, 0), 1'b1, BAD_DATE);
    add_row(mk_dates(YEAR_TOP, 15, 31, YEAR_TOP, 15, 31), 1'b1, BAD_DATE);
    // Plain cases and the range extremes
    add_row(mk_dates(2000, 2, 29, 2000, 2, 29), 1'b1, good_gap(0));
    add_row(mk_dates(2001, 12, 31, 2001, 1, 1), 1'b1, good_gap(364));
    add_row(mk_dates(MAX_YEAR, 12, 31, 0, 1, 1), 1'b1, good_gap(3652423));
    add_row(mk_dates(0, 1, 1, 4, 12, 31), 1'b1, good_gap(-365));
    add_row(mk_dates(0, 2, 29, 0, 1, 1), 1'b1, good_gap(59));
    add_row(mk_dates(2004, 2, 29, 2004, 2, 28), 1'b1, good_gap(1));
    add_row(mk_dates(2023, 1, 1, 2023, 12, 31), 1'b1, good_gap(-364));
    // Leap and century crossings
    add_row(mk_dates(2400, 2, 29, 2399, 12, 31), 1'b0, '0);
    add_row(mk_dates(2000, 3, 1, 1999, 2, 28), 1'b0, '0);
    add_row(mk_dates(1601, 1, 1, 1600, 1, 1), 1'b0, '0);
    add_row(mk_dates(2000, 1, 1, 1999, 12, 31), 1'b0, '0);
    add_row(mk_dates(1900, 3, 1, 1800, 2, 28), 1'b0, '0);
    add_row(mk_dates(1999, 6, 30, 2003, 11, 30), 1'b0, '0);

    send_idle_pct = 27;
    recv_stall_pct = 88;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_word(row.word, row.typed ? row.want : predict_day_gap(row.word));
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_stall_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        cdd_pkg::req_t w;
        w = random_dates();
        send_word(w, predict_day_gap(w));
      end
      // Let the pipe run empty before the next phase
      hold_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_gaps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
